>>> rtl/alkc_pkg.sv
`default_nettype none
package alkc_pkg;

    localparam int KEY_W   = 64;
    localparam int LEN_W   = 32;
    localparam int FUNC_W  = 2;
    localparam int LFSR_W  = 16;
    localparam int CFG_W   = 32;
    localparam int ROW_W   = KEY_W + LEN_W;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd3;

    // register indexes
    localparam logic CFG_ENABLE     = 1'b0;
    localparam logic CFG_MIN_LENGTH = 1'b1;

    localparam logic [LFSR_W-1:0] LFSR_RESET       = 16'hACE1;
    localparam logic [LEN_W-1:0]  MIN_LENGTH_RESET = 32'd100;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [KEY_W-1:0]        key;
        logic [LEN_W-1:0]        length;
        logic signed [LEN_W-1:0] delta;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] found_length;
    } rsp_t;

endpackage
`default_nettype wire

>>> rtl/alkc_ram.sv
`default_nettype none
module alkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/address_keyed_length_cache.sv
// channel   | ports                          | handshake
// ----------+--------------------------------+----------------------------------
// request   | start, busy, req (req_t)       | taken when start && !busy
// result    | done, rsp (rsp_t)              | done high one cycle, no stall
// config    | wr_en, wr_index, wr_data       | written when wr_en high
//
// every request scans the table one entry per cycle through the ram read port:
// busy stays high through the scan, the last compare and the action state, done follows in the next cycle
// an add that would insert but finds neither its key nor an empty slot reduces the lfsr
// modulo ENTRIES: reciprocal multiply, subtract, one correcting subtract
// reset clears the per-entry valid bits at once, so no clearing pass is run
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none
module address_keyed_length_cache
    import alkc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire req_t             req,
    output logic                  done,
    output rsp_t                  rsp,
    input  wire logic             wr_en,
    input  wire logic             wr_index,
    input  wire logic [CFG_W-1:0] wr_data
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int RECIP_W = 32;
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [LFSR_W-1:0]  ENT_L    = LFSR_W'(ENTRIES);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'd1 << RECIP_W) / ENTRIES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_LAST = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_ACT  = 3'd4;
    localparam logic [2:0] ST_SUB  = 3'd5;
    localparam logic [2:0] ST_FIX  = 3'd6;

    logic [2:0]         state_reg,     state_next;
    logic [IDX_W-1:0]   rd_idx_reg,    rd_idx_next;
    logic               cmp_on_reg,    cmp_on_next;
    logic [IDX_W-1:0]   cmp_idx_reg,   cmp_idx_next;
    logic               vbit_reg,      vbit_next;
    logic               found_reg,     found_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic [LEN_W-1:0]   match_len_reg, match_len_next;
    logic               empty_ok_reg,  empty_ok_next;
    logic [IDX_W-1:0]   empty_idx_reg, empty_idx_next;
    logic [LFSR_W-1:0]  lfsr_reg,      lfsr_next;
    logic [LFSR_W-1:0]  quot_reg,      quot_next;
    logic [LFSR_W-1:0]  rem_reg,       rem_next;
    req_t               cmd_reg,       cmd_next;
    logic               enable_reg,    enable_next;
    logic [LEN_W-1:0]   min_len_reg,   min_len_next;
    logic               done_reg,      done_next;
    rsp_t               rsp_reg,       rsp_next;
    logic [ENTRIES-1:0] valid_reg,     valid_next;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [ROW_W-1:0]          ram_wdata;
    logic [ROW_W-1:0]          ram_rdata;
    logic [KEY_W-1:0]          row_key;
    logic [LEN_W-1:0]          row_len;
    logic                      hit_now;
    logic                      empty_now;
    logic                      key_nz;
    logic                      need_victim;
    logic [LFSR_W+RECIP_W-1:0] recip_prod;
    logic [LFSR_W-1:0]         lfsr_step;
    logic [IDX_W-1:0]          ins_idx;

    alkc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign row_key = ram_rdata[ROW_W-1 -: KEY_W];
    assign row_len = ram_rdata[LEN_W-1:0];
    assign key_nz  = (cmd_reg.key != '0);

    // compare of the row read in the previous cycle
    assign hit_now   = cmp_on_reg && vbit_reg && (row_key == cmd_reg.key);
    assign empty_now = cmp_on_reg && (!vbit_reg || (row_key == '0));

    // fibonacci lfsr, taps 16 14 13 11
    assign lfsr_step = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                        lfsr_reg[LFSR_W-1:1]};

    // quotient estimate by reciprocal, low by at most one
    assign recip_prod = lfsr_reg * RECIP;

    assign ins_idx = empty_ok_reg ? empty_idx_reg : rem_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_on_next    = 1'b0;
        cmp_idx_next   = rd_idx_reg;
        vbit_next      = valid_reg[rd_idx_reg];
        found_next     = found_reg | hit_now;
        match_idx_next = (!found_reg && hit_now) ? cmp_idx_reg : match_idx_reg;
        match_len_next = (!found_reg && hit_now) ? row_len : match_len_reg;
        empty_ok_next  = empty_ok_reg | empty_now;
        empty_idx_next = empty_now ? cmp_idx_reg : empty_idx_reg;
        lfsr_next      = lfsr_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        cmd_next       = cmd_reg;
        enable_next    = enable_reg;
        min_len_next   = min_len_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        valid_next     = valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = match_idx_reg;
        ram_wdata      = {cmd_reg.key, cmd_reg.length};
        need_victim    = 1'b0;

        // configuration writes
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_ENABLE:     enable_next  = wr_data[0];
                CFG_MIN_LENGTH: min_len_next = wr_data[LEN_W-1:0];
                default:        ;
            endcase
        end

        // sequencer
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = req;
                    rd_idx_next   = '0;
                    found_next    = 1'b0;
                    empty_ok_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmp_on_next = 1'b1;
                if (rd_idx_reg == LAST_IDX)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                need_victim = key_nz && enable_reg && (cmd_reg.func == FUNC_ADD)
                              && !found_next && !empty_ok_next
                              && (cmd_reg.length > min_len_reg);
                if (need_victim)
                begin
                    lfsr_next  = lfsr_step;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_ACT;
                end
            end
            ST_DIV:
            begin
                quot_next  = recip_prod[LFSR_W+RECIP_W-1 -: LFSR_W];
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                rem_next   = lfsr_reg - quot_reg * ENT_L;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                // estimate may leave one extra multiple of ENTRIES
                if (rem_reg >= ENT_L)
                begin
                    rem_next = rem_reg - ENT_L;
                end
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                done_next             = 1'b1;
                rsp_next.hit          = 1'b0;
                rsp_next.found_length = '0;
                state_next            = ST_IDLE;
                if (key_nz)
                begin
                    unique case (cmd_reg.func)
                        FUNC_LOOKUP:
                        begin
                            if (enable_reg && found_reg)
                            begin
                                rsp_next.hit          = 1'b1;
                                rsp_next.found_length = match_len_reg;
                            end
                        end
                        FUNC_ADD:
                        begin
                            if (enable_reg && found_reg)
                            begin
                                rsp_next.hit = 1'b1;
                                if (cmd_reg.length < min_len_reg)
                                begin
                                    valid_next[match_idx_reg] = 1'b0;
                                end
                                else
                                begin
                                    ram_we = 1'b1;
                                end
                            end
                            else if (enable_reg && (cmd_reg.length > min_len_reg))
                            begin
                                ram_we              = 1'b1;
                                ram_waddr           = ins_idx;
                                valid_next[ins_idx] = 1'b1;
                            end
                        end
                        FUNC_UPDATE:
                        begin
                            if (found_reg)
                            begin
                                rsp_next.hit = 1'b1;
                                ram_we       = 1'b1;
                                ram_wdata    = {cmd_reg.key, match_len_reg + cmd_reg.delta};
                            end
                        end
                        FUNC_DELETE:
                        begin
                            // an emptied slot's length is never observed again
                            if (found_reg)
                            begin
                                rsp_next.hit              = 1'b1;
                                valid_next[match_idx_reg] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cmp_on_reg  <= 1'b0;
            found_reg   <= 1'b0;
            empty_ok_reg <= 1'b0;
            lfsr_reg    <= LFSR_RESET;
            enable_reg  <= 1'b1;
            min_len_reg <= MIN_LENGTH_RESET;
            done_reg    <= 1'b0;
            valid_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_on_reg  <= cmp_on_next;
            found_reg   <= found_next;
            empty_ok_reg <= empty_ok_next;
            lfsr_reg    <= lfsr_next;
            enable_reg  <= enable_next;
            min_len_reg <= min_len_next;
            done_reg    <= done_next;
            valid_reg   <= valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        vbit_reg      <= vbit_next;
        match_idx_reg <= match_idx_next;
        match_len_reg <= match_len_next;
        empty_idx_reg <= empty_idx_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        cmd_reg       <= cmd_next;
        rsp_reg       <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // checks
    a_done_after_act: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_ACT))
        else $error("result strobe without a finished request");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_zero_key_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && (cmd_reg.key == '0) |-> !rsp.hit)
        else $error("hit reported for key zero");

    a_len_lookup_only: assert property (@(posedge clk) disable iff (!rst_n)
        done && (cmd_reg.func != FUNC_LOOKUP) |-> (rsp.found_length == '0))
        else $error("length reported for a non-lookup request");

endmodule
`default_nettype wire
